[hdl/bda_pkg.sv]
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types, codes and defaults of the banker's safety check block.
// ----------------------------------------------------------------------------
`default_nettype none

package bda_pkg;

    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_MAX_RESOURCES = 8;
    localparam int DEF_COUNT_BITS    = 8;

    // Width of process and resource counts taken from the registers.
    localparam int NCW = 5;

    typedef enum logic [2:0] {
        KIND_AVAIL   = 3'd0,
        KIND_MAXIMUM = 3'd1,
        KIND_ALLOC   = 3'd2,
        KIND_REQUEST = 3'd3,
        KIND_CHECK   = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNSAFE  = 2'd1,
        STATUS_EXCEEDS = 2'd2,
        STATUS_WAIT    = 2'd3
    } status_t;

    typedef enum logic {
        REG_NUM_PROCESSES = 1'b0,
        REG_NUM_RESOURCES = 1'b1
    } reg_index_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [3:0] process_index;
        logic [2:0] resource_index;
        logic [7:0] amount;
        logic       last_element;
    } item_t;

    typedef struct packed {
        logic       result_type;
        logic [3:0] seq_process;
        logic [1:0] status;
        logic       last;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    accept;
        logic    r_clear;
        logic    r_inc;
        logic    req_cmp;
        logic    grant_wr;
        logic    undo;
        logic    scan_addr;
        logic    scan_init;
        logic    work_add;
        logic    mark_done;
        logic    p_next;
        logic    pass_restart;
        logic    out_load;
        logic    out_verdict;
        status_t out_status;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_req_go;
        logic item_check;
        logic item_p_ok;
        logic r_last;
        logic p_last;
        logic fin_p;
        logic elem_fits;
        logic exceed_any;
        logic wait_any;
        logic all_done;
        logic progress;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

[hdl/bda_ram.sv]
// ----------------------------------------------------------------------------
// bda_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

[hdl/bda_ctrl.sv]
// ----------------------------------------------------------------------------
// bda_ctrl
// Sequencer for loads, request tests, grant and rollback, and the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_ctrl
    import bda_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic item_valid,
    output logic      item_stall,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [14:0] {
        ST_IDLE    = 15'b000000000000001,
        ST_REQ_RD  = 15'b000000000000010,
        ST_REQ_CMP = 15'b000000000000100,
        ST_REQ_DEC = 15'b000000000001000,
        ST_G_RD    = 15'b000000000010000,
        ST_G_WR    = 15'b000000000100000,
        ST_INIT    = 15'b000000001000000,
        ST_VISIT   = 15'b000000010000000,
        ST_S_RD    = 15'b000000100000000,
        ST_S_CMP   = 15'b000001000000000,
        ST_A_RD    = 15'b000010000000000,
        ST_A_ADD   = 15'b000100000000000,
        ST_ENTRY   = 15'b001000000000000,
        ST_P_NEXT  = 15'b010000000000000,
        ST_VERDICT = 15'b100000000000000
    } state_t;

    state_t  state_reg, state_next;
    logic    undo_reg, undo_next;
    logic    req_run_reg, req_run_next;
    status_t verdict_reg, verdict_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        undo_next    = undo_reg;
        req_run_next = req_run_reg;
        verdict_next = verdict_reg;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.item_req_go)
                    begin
                        if (!sts.item_p_ok)
                        begin
                            verdict_next = STATUS_EXCEEDS;
                            state_next   = ST_VERDICT;
                        end
                        else
                        begin
                            cmd.r_clear  = 1'b1;
                            undo_next    = 1'b0;
                            req_run_next = 1'b1;
                            state_next   = ST_REQ_RD;
                        end
                    end
                    else if (sts.item_check)
                    begin
                        req_run_next = 1'b0;
                        state_next   = ST_INIT;
                    end
                end
            end
            ST_REQ_RD:
            begin
                state_next = ST_REQ_CMP;
            end
            ST_REQ_CMP:
            begin
                cmd.req_cmp = 1'b1;
                if (sts.r_last)
                begin
                    state_next = ST_REQ_DEC;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = ST_REQ_RD;
                end
            end
            ST_REQ_DEC:
            begin
                if (sts.exceed_any)
                begin
                    verdict_next = STATUS_EXCEEDS;
                    state_next   = ST_VERDICT;
                end
                else if (sts.wait_any)
                begin
                    verdict_next = STATUS_WAIT;
                    state_next   = ST_VERDICT;
                end
                else
                begin
                    cmd.r_clear = 1'b1;
                    state_next  = ST_G_RD;
                end
            end
            ST_G_RD:
            begin
                state_next = ST_G_WR;
            end
            ST_G_WR:
            begin
                cmd.grant_wr = 1'b1;
                cmd.undo     = undo_reg;
                if (sts.r_last)
                begin
                    state_next = undo_reg ? ST_VERDICT : ST_INIT;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = ST_G_RD;
                end
            end
            ST_INIT:
            begin
                cmd.scan_init = 1'b1;
                state_next    = ST_VISIT;
            end
            ST_VISIT:
            begin
                cmd.scan_addr = 1'b1;
                if (sts.fin_p)
                begin
                    state_next = ST_P_NEXT;
                end
                else
                begin
                    cmd.r_clear = 1'b1;
                    state_next  = ST_S_RD;
                end
            end
            ST_S_RD:
            begin
                cmd.scan_addr = 1'b1;
                state_next    = ST_S_CMP;
            end
            ST_S_CMP:
            begin
                cmd.scan_addr = 1'b1;
                if (!sts.elem_fits)
                begin
                    state_next = ST_P_NEXT;
                end
                else if (sts.r_last)
                begin
                    cmd.r_clear = 1'b1;
                    state_next  = ST_A_RD;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = ST_S_RD;
                end
            end
            ST_A_RD:
            begin
                cmd.scan_addr = 1'b1;
                state_next    = ST_A_ADD;
            end
            ST_A_ADD:
            begin
                cmd.scan_addr = 1'b1;
                cmd.work_add  = 1'b1;
                if (sts.r_last)
                begin
                    cmd.mark_done = 1'b1;
                    state_next    = ST_ENTRY;
                end
                else
                begin
                    cmd.r_inc  = 1'b1;
                    state_next = ST_A_RD;
                end
            end
            ST_ENTRY:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_status = STATUS_OK;
                    state_next     = ST_P_NEXT;
                end
            end
            ST_P_NEXT:
            begin
                if (sts.p_last)
                begin
                    if (sts.all_done)
                    begin
                        verdict_next = STATUS_OK;
                        state_next   = ST_VERDICT;
                    end
                    else if (!sts.progress)
                    begin
                        verdict_next = STATUS_UNSAFE;
                        if (req_run_reg)
                        begin
                            // Unsafe after a tentative grant: give it back.
                            undo_next   = 1'b1;
                            cmd.r_clear = 1'b1;
                            state_next  = ST_G_RD;
                        end
                        else
                        begin
                            state_next = ST_VERDICT;
                        end
                    end
                    else
                    begin
                        cmd.pass_restart = 1'b1;
                        state_next       = ST_VISIT;
                    end
                end
                else
                begin
                    cmd.p_next = 1'b1;
                    state_next = ST_VISIT;
                end
            end
            ST_VERDICT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load    = 1'b1;
                    cmd.out_verdict = 1'b1;
                    cmd.out_status  = verdict_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            undo_reg    <= 1'b0;
            req_run_reg <= 1'b0;
            verdict_reg <= STATUS_OK;
        end
        else
        begin
            state_reg   <= state_next;
            undo_reg    <= undo_next;
            req_run_reg <= req_run_next;
            verdict_reg <= verdict_next;
        end
    end

endmodule

`default_nettype wire

[hdl/bda_datapath.sv]
// ----------------------------------------------------------------------------
// bda_datapath
// Tables, vectors, counters and the result register of the safety check.
// ----------------------------------------------------------------------------
`default_nettype none

module bda_datapath
    import bda_pkg::*;
#(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [NCW-1:0] np,
    input  wire logic [NCW-1:0] nr,
    input  wire item_t          item,
    input  wire cmd_t           cmd,
    output sts_t                sts,
    output logic                result_valid,
    input  wire logic           result_stall,
    output result_t             result
);

    localparam int PW    = $clog2(MAX_PROCESSES);
    localparam int RW    = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int WB    = COUNT_BITS + 4;
    localparam int AW    = PW + RW;
    localparam int DEPTH = MAX_PROCESSES * (2 ** RW);
    localparam int PCW   = (PW > NCW) ? PW : NCW;

    logic [COUNT_BITS-1:0] avail_reg [MAX_RESOURCES];
    logic [COUNT_BITS-1:0] pend_reg  [MAX_RESOURCES];
    logic [WB-1:0]         work_reg  [MAX_RESOURCES];
    logic [MAX_PROCESSES-1:0] fin_reg;
    logic [RW-1:0]         r_reg;
    logic [PW-1:0]         p_reg;
    logic [PW-1:0]         req_p_reg;
    logic [NCW-1:0]        done_reg;
    logic                  progress_reg;
    logic                  exceed_reg;
    logic                  wait_reg;
    logic                  out_valid_reg;
    result_t               out_reg;

    logic [PW-1:0]         p_in;
    logic [RW-1:0]         r_in;
    logic                  p_ok;
    logic                  r_ok;
    logic [COUNT_BITS-1:0] amt;
    logic                  ld_avail;
    logic                  ld_max;
    logic                  ld_alloc;
    logic                  ld_pend;
    logic [AW-1:0]         raddr;
    logic [AW-1:0]         load_addr;
    logic [COUNT_BITS-1:0] max_rd;
    logic [COUNT_BITS-1:0] alloc_rd;
    logic                  alloc_we;
    logic [AW-1:0]         alloc_waddr;
    logic [COUNT_BITS-1:0] alloc_wdata;
    logic [COUNT_BITS-1:0] pend_r;
    logic [COUNT_BITS:0]   req_sum;
    logic [WB:0]           work_sum;
    logic [WB-1:0]         work_sat;
    logic                  out_free;

    assign p_in = PW'(item.process_index);
    assign r_in = RW'(item.resource_index);
    assign p_ok = ({1'b0, item.process_index} < np);
    assign r_ok = ({2'b00, item.resource_index} < nr);
    assign amt  = COUNT_BITS'(item.amount);

    assign ld_avail = cmd.accept && (item.kind == KIND_AVAIL) && r_ok;
    assign ld_max   = cmd.accept && (item.kind == KIND_MAXIMUM) && p_ok && r_ok;
    assign ld_alloc = cmd.accept && (item.kind == KIND_ALLOC) && p_ok && r_ok;
    assign ld_pend  = cmd.accept && (item.kind == KIND_REQUEST) && r_ok;

    assign load_addr = {p_in, r_in};
    assign raddr     = {(cmd.scan_addr ? p_reg : req_p_reg), r_reg};
    assign pend_r    = pend_reg[r_reg];

    // Allocation is rewritten by loads and by grant or rollback.
    assign alloc_we    = ld_alloc || cmd.grant_wr;
    assign alloc_waddr = cmd.grant_wr ? {req_p_reg, r_reg} : load_addr;
    assign alloc_wdata = !cmd.grant_wr ? amt :
                         (cmd.undo ? (alloc_rd - pend_r) : (alloc_rd + pend_r));

    bda_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_max_ram (
        .clk   (clk),
        .we    (ld_max),
        .waddr (load_addr),
        .wdata (amt),
        .raddr (raddr),
        .rdata (max_rd)
    );

    bda_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (DEPTH)
    ) u_alloc_ram (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (alloc_waddr),
        .wdata (alloc_wdata),
        .raddr (raddr),
        .rdata (alloc_rd)
    );

    assign req_sum  = {1'b0, pend_r} + {1'b0, alloc_rd};
    assign work_sum = {1'b0, work_reg[r_reg]} + (WB + 1)'(alloc_rd);
    assign work_sat = work_sum[WB] ? {WB{1'b1}} : work_sum[WB-1:0];
    assign out_free = !out_valid_reg || !result_stall;

    always_comb
    begin
        sts             = '0;
        sts.item_req_go = (item.kind == KIND_REQUEST) && item.last_element;
        sts.item_check  = (item.kind == KIND_CHECK);
        sts.item_p_ok   = p_ok;
        sts.r_last      = (NCW'(r_reg) == (nr - NCW'(1)));
        sts.p_last      = (PCW'(p_reg) == (PCW'(np) - PCW'(1)));
        sts.fin_p       = fin_reg[p_reg];
        // Need fits when maximum does not exceed work plus allocation.
        sts.elem_fits   = ((WB + 1)'(max_rd) <= work_sum);
        sts.exceed_any  = exceed_reg;
        sts.wait_any    = wait_reg;
        sts.all_done    = (done_reg == np);
        sts.progress    = progress_reg;
        sts.out_free    = out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                avail_reg[i] <= '0;
            end
        end
        else if (ld_avail)
        begin
            avail_reg[r_in] <= amt;
        end
        else if (cmd.grant_wr)
        begin
            avail_reg[r_reg] <= cmd.undo ? (avail_reg[r_reg] + pend_r)
                                         : (avail_reg[r_reg] - pend_r);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld_pend)
        begin
            pend_reg[r_in] <= amt;
        end
        if (cmd.scan_init)
        begin
            for (int i = 0; i < MAX_RESOURCES; i++)
            begin
                work_reg[i] <= WB'(avail_reg[i]);
            end
        end
        else if (cmd.work_add)
        begin
            work_reg[r_reg] <= work_sat;
        end
        if (cmd.accept)
        begin
            req_p_reg <= p_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_reg      <= '0;
            r_reg        <= '0;
            p_reg        <= '0;
            done_reg     <= '0;
            progress_reg <= 1'b0;
            exceed_reg   <= 1'b0;
            wait_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.r_clear)
            begin
                r_reg <= '0;
            end
            else if (cmd.r_inc)
            begin
                r_reg <= r_reg + RW'(1);
            end

            if (cmd.accept)
            begin
                exceed_reg <= 1'b0;
                wait_reg   <= 1'b0;
            end
            else if (cmd.req_cmp)
            begin
                if (req_sum > {1'b0, max_rd})
                begin
                    exceed_reg <= 1'b1;
                end
                if (pend_r > avail_reg[r_reg])
                begin
                    wait_reg <= 1'b1;
                end
            end

            if (cmd.scan_init)
            begin
                fin_reg      <= '0;
                p_reg        <= '0;
                done_reg     <= '0;
                progress_reg <= 1'b0;
            end
            else
            begin
                if (cmd.mark_done)
                begin
                    fin_reg[p_reg] <= 1'b1;
                    done_reg       <= done_reg + NCW'(1);
                    progress_reg   <= 1'b1;
                end
                else if (cmd.pass_restart)
                begin
                    progress_reg <= 1'b0;
                end
                if (cmd.pass_restart)
                begin
                    p_reg <= '0;
                end
                else if (cmd.p_next)
                begin
                    p_reg <= p_reg + PW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_reg.result_type <= cmd.out_verdict;
            out_reg.seq_process <= cmd.out_verdict ? 4'd0 : 4'(p_reg);
            out_reg.status      <= cmd.out_status;
            out_reg.last        <= cmd.out_verdict;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

`default_nettype wire

[hdl/bankers_deadlock_avoidance.sv]
// ----------------------------------------------------------------------------
// bankers_deadlock_avoidance
// Banker's algorithm resource safety check with request test and rollback.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Payload
//  item      in         item_valid/stall     item_t (kind, indexes, amount)
//  result    out        result_valid/stall   result_t (sequence or verdict)
//  config    in         APB psel/penable     num_processes, num_resources
//
// Loads are taken in the idle state. A request test reads and compares each
// resource in turn, then decides; a grant or rollback rewrites each in turn.
// A scan pass visits each process and tests and adds one resource at a time,
// as each table has a single read port; up to P passes run for P processes.
// Reset clears control state and the available vector; tables need no pass.
// A stalled result holds in the output register and pauses the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module bankers_deadlock_avoidance
    import bda_pkg::*;
#(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
    parameter int COUNT_BITS    = DEF_COUNT_BITS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire item_t       item,
    output logic             result_valid,
    input  wire logic        result_stall,
    output result_t          result,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int PROC_LIMIT = (MAX_PROCESSES < 16) ? MAX_PROCESSES : 16;

    logic [4:0]     num_processes_reg;
    logic [3:0]     num_resources_reg;
    logic           cfg_wr;
    reg_index_t     cfg_sel;
    logic [NCW-1:0] np;
    logic [NCW-1:0] nr;
    cmd_t           cmd;
    sts_t           sts;

    assign pready  = 1'b1;
    assign cfg_sel = reg_index_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_processes_reg <= 5'd1;
            num_resources_reg <= 4'd1;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_NUM_PROCESSES: num_processes_reg <= pwdata[4:0];
                REG_NUM_RESOURCES: num_resources_reg <= pwdata[3:0];
                default:           num_processes_reg <= num_processes_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_NUM_PROCESSES: prdata = {27'd0, num_processes_reg};
            REG_NUM_RESOURCES: prdata = {28'd0, num_resources_reg};
            default:           prdata = '0;
        endcase
    end

    // Counts in use: zero counts as one, large values saturate.
    always_comb
    begin
        if (num_processes_reg == 5'd0)
        begin
            np = NCW'(1);
        end
        else if (32'(num_processes_reg) > PROC_LIMIT)
        begin
            np = NCW'(PROC_LIMIT);
        end
        else
        begin
            np = NCW'(num_processes_reg);
        end

        if (num_resources_reg == 4'd0)
        begin
            nr = NCW'(1);
        end
        else if (32'(num_resources_reg) > MAX_RESOURCES)
        begin
            nr = NCW'(MAX_RESOURCES);
        end
        else
        begin
            nr = NCW'(num_resources_reg);
        end
    end

    bda_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    bda_datapath #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .COUNT_BITS    (COUNT_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .np           (np),
        .nr           (nr),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result register overwritten while held");

    a_entry_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.result_type |->
            (result.status == STATUS_OK) && !result.last)
        else $error("sequence entry carries verdict fields");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.result_type |->
            result.last && (result.seq_process == 4'd0))
        else $error("verdict not marked as last");

    a_no_grant_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |-> !cmd.grant_wr && !cmd.work_add)
        else $error("table update while taking an item");

endmodule

`default_nettype wire
